// ===== sv/sha4l_pkg.sv =====
package sha4l_pkg;

  localparam int LANES = 4;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS = 64;
  localparam int DIGEST_WORDS = 8;

  typedef logic [31:0] word_t;
  typedef logic [LANES-1:0][31:0] lanes_t;
  typedef logic [DIGEST_WORDS-1:0][31:0] hstate_t;

  typedef struct packed {
    logic [31:0] word_lane0;
    logic [31:0] word_lane1;
    logic [31:0] word_lane2;
    logic [31:0] word_lane3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_lane0;
    logic [31:0] digest_lane1;
    logic [31:0] digest_lane2;
    logic [31:0] digest_lane3;
    logic        final_word;
  } out_item_t;

  // round issue request, top level to schedule unit
  typedef struct packed {
    logic       valid;
    logic [5:0] t;
  } sched_req_t;

  // per-round control, schedule unit to the lane round units
  typedef struct packed {
    logic valid;
    logic last;
  } rnd_ctl_t;

  // entry 0 is H0
  localparam hstate_t START_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ssig0(input word_t x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

// ===== sv/sha256_single_block_four_lane_unit.sv =====
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    in_data   (one message word per lane)
// out_     output     out_valid / out_ready  out_data  (one digest word per lane)
//
// Words 1..15 of a block are written into the schedule store; the sixteenth starts a run of
// 64 rounds, one per cycle, paced by the schedule store's two read ports and
// passing through the read and schedule stages. The eight digest transfers then
// leave through the output register, one per cycle when out_ready is high,
// while words 1..15 of the next block are already taken in.
// Reset clears the word count and the control; the schedule store is not cleared.
module sha256_single_block_four_lane_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha4l_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha4l_pkg::out_item_t out_data
);
  import sha4l_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [6:0] iss_r, iss_nxt;
  logic [2:0] j_r, j_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;

  logic       in_xfer;
  logic       blk_init;
  logic       out_load;
  lanes_t     load_data;
  sched_req_t req;
  rnd_ctl_t   rnd_ctl;
  lanes_t     kw;
  hstate_t    lane_v [LANES];
  lanes_t     digest;

  assign in_ready = (state_r == ST_LOAD) || ((state_r == ST_OUT) && (cnt_r != 4'd15));
  assign in_xfer  = in_valid && in_ready;
  assign blk_init = in_xfer && (cnt_r == 4'd15);

  assign load_data[0] = in_data.word_lane0;
  assign load_data[1] = in_data.word_lane1;
  assign load_data[2] = in_data.word_lane2;
  assign load_data[3] = in_data.word_lane3;

  assign req.valid = (state_r == ST_RUN) && !iss_r[6];
  assign req.t     = iss_r[5:0];

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  sha4l_sched u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_we   (in_xfer),
    .load_addr (cnt_r),
    .load_data (load_data),
    .req       (req),
    .rnd_ctl   (rnd_ctl),
    .kw        (kw)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sha4l_round u_round (
      .clk  (clk),
      .init (blk_init),
      .step (rnd_ctl.valid),
      .kw   (kw[l]),
      .v_o  (lane_v[l])
    );
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      digest[l] = lane_v[l][j_r] + START_H[j_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      cnt_nxt = cnt_r + 4'd1;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (blk_init) begin
          state_nxt = ST_RUN;
          iss_nxt   = 7'd0;
        end
      end
      ST_RUN: begin
        if (req.valid) begin
          iss_nxt = iss_r + 7'd1;
        end
        if (rnd_ctl.valid && rnd_ctl.last) begin
          state_nxt = ST_OUT;
          j_nxt     = 3'd0;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          j_nxt         = j_r + 3'd1;
          if (j_r == 3'd7) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= 4'd0;
      iss_r       <= 7'd0;
      j_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.digest_lane0 <= digest[0];
      out_data_r.digest_lane1 <= digest[1];
      out_data_r.digest_lane2 <= digest[2];
      out_data_r.digest_lane3 <= digest[3];
      out_data_r.final_word   <= (j_r == 3'd7);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_round_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_ctl.valid |-> (state_r == ST_RUN))
    else $error("round step outside the hashing run");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (rnd_ctl.valid && rnd_ctl.last) |=> (state_r == ST_OUT))
    else $error("last round did not start digest output");

  a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
    blk_init |=> ((state_r == ST_RUN) && (cnt_r == 4'd0)))
    else $error("sixteenth word did not start a run");

  a_no_load_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !in_ready)
    else $error("word accepted while the schedule store is in use");

endmodule

// ===== sv/sha4l_sched.sv =====
module sha4l_sched (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_we,
  input  logic [3:0]            load_addr,
  input  sha4l_pkg::lanes_t     load_data,
  input  sha4l_pkg::sched_req_t req,
  output sha4l_pkg::rnd_ctl_t   rnd_ctl,
  output sha4l_pkg::lanes_t     kw
);
  import sha4l_pkg::*;

  // circular schedule store: entry t mod 16 holds w[t] for all four lanes
  lanes_t mem [BLOCK_WORDS];

  lanes_t     rd_a_r;
  lanes_t     rd_b_r;
  logic       s_valid_r;
  logic [5:0] s_t_r;
  lanes_t     w1_r;
  lanes_t     w2_r;
  lanes_t     prevb_r;
  lanes_t     kw_r;
  logic       rnd_valid_r;
  logic       rnd_last_r;

  logic [3:0] raddr_a;
  logic [3:0] raddr_b;
  logic       s_ext;
  lanes_t     w_t;
  logic       mem_we;
  logic [3:0] mem_waddr;
  lanes_t     mem_wdata;

  // port A: w[t] for the first sixteen rounds, w[t-7] after
  // port B: w[t-15]; held a round it serves as w[t-16]
  assign raddr_a = (req.t[5:4] == 2'd0) ? req.t[3:0] : req.t[3:0] + 4'd9;
  assign raddr_b = req.t[3:0] + 4'd1;

  assign s_ext = (s_t_r[5:4] != 2'd0);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (s_ext) begin
        w_t[l] = ssig1(w2_r[l]) + rd_a_r[l] + ssig0(rd_b_r[l]) + prevb_r[l];
      end else begin
        w_t[l] = rd_a_r[l];
      end
    end
  end

  assign mem_we    = (s_valid_r && s_ext) || load_we;
  assign mem_waddr = (s_valid_r && s_ext) ? s_t_r[3:0] : load_addr;
  assign mem_wdata = (s_valid_r && s_ext) ? w_t : load_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    s_t_r <= req.t;
    if (s_valid_r) begin
      w2_r    <= w1_r;
      w1_r    <= w_t;
      prevb_r <= rd_b_r;
      for (int l = 0; l < LANES; l++) begin
        kw_r[l] <= w_t[l] + ROUND_K[s_t_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      rnd_valid_r <= 1'b0;
      rnd_last_r  <= 1'b0;
    end else begin
      s_valid_r   <= req.valid;
      rnd_valid_r <= s_valid_r;
      rnd_last_r  <= s_valid_r && (s_t_r == 6'd63);
    end
  end

  assign rnd_ctl.valid = rnd_valid_r;
  assign rnd_ctl.last  = rnd_last_r;
  assign kw            = kw_r;

endmodule

// ===== sv/sha4l_round.sv =====
module sha4l_round (
  input  logic               clk,
  input  logic               init,
  input  logic               step,
  input  logic [31:0]        kw,
  output sha4l_pkg::hstate_t v_o
);
  import sha4l_pkg::*;

  hstate_t v_r;
  hstate_t v_nxt;
  word_t   ch;
  word_t   maj;
  word_t   t1;
  word_t   t2;

  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + bsig1(v_r[4]) + ch + kw;
    t2    = bsig0(v_r[0]) + maj;
    v_nxt = v_r;
    if (init) begin
      v_nxt = START_H;
    end else if (step) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign v_o = v_r;

endmodule
